### design/tasp_pkg.sv
// ----------------------------------------------------------------------------
// tasp_pkg
// Shared types, widths, the member offset table and a rounding helper for the
// terrain aligned squad placer.
// ----------------------------------------------------------------------------
package tasp_pkg;

    localparam int VW   = 20;          // orientation vector component width
    localparam int PW   = 34;          // heading product accumulator width
    localparam int SW   = 38;          // sum of squares width
    localparam int NW   = SW + 20;     // radicand width
    localparam int RW   = NW / 2;      // root width
    localparam int DW   = 45;          // dividend and quotient width
    localparam int SQRT_STEPS = NW / 2;
    localparam int KW   = 4;           // member index width
    localparam int TABLE_SIZE = 9;

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [15:0]   unit_t;

    typedef struct packed {
        logic          load;
        logic          mul_en;
        logic [2:0]    mul_step;
        logic          vec_load;
        logic [1:0]    axis;
        logic          sq_en;
        logic [1:0]    sq_idx;
        logic          sqrt_init;
        logic          sqrt_step;
        logic          div_init;
        logic          comp;
        logic          div_step;
        logic          div_store;
        logic          zero_store;
        logic          emit;
        logic [KW-1:0] k;
        logic          last;
    } tasp_cmd_t;

    typedef struct packed {
        logic          chg;
        logic          zero;
        logic          out_free;
        logic [KW-1:0] count;
    } tasp_stat_t;

    function automatic logic signed [5:0] off_x(input logic [KW-1:0] k);
        logic signed [5:0] r;
        case (k)
            4'd1:    r = -6'sd5;
            4'd2:    r = 6'sd5;
            4'd3:    r = 6'sd8;
            4'd4:    r = -6'sd6;
            4'd6:    r = 6'sd20;
            4'd8:    r = -6'sd20;
            default: r = 6'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [5:0] off_y(input logic [KW-1:0] k);
        logic signed [5:0] r;
        case (k)
            4'd1:    r = 6'sd5;
            4'd2:    r = 6'sd12;
            4'd3:    r = -6'sd5;
            4'd4:    r = -6'sd10;
            4'd5:    r = 6'sd20;
            4'd7:    r = -6'sd20;
            default: r = 6'sd0;
        endcase
        return r;
    endfunction

    // product back to q2.14, half away from zero
    function automatic vec_t round14(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        q   = (mag + PW'(8192)) >> 14;
        return p[PW-1] ? vec_t'(-$signed(q[VW-1:0])) : vec_t'(q[VW-1:0]);
    endfunction

endpackage

### design/tasp_if.sv
// ----------------------------------------------------------------------------
// tasp channel interfaces
// Object request, placed member and squad size write channels.
// ----------------------------------------------------------------------------
interface tasp_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         detail_level;
    logic signed [31:0] ground_height;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;
    logic [15:0]        rel_heading;
    logic               is_moving;
    logic [31:0]        clock_ms;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;

    modport source (output valid, detail_level, ground_height, normal_x, normal_y, normal_z,
                    heading_cos, heading_sin, rel_heading, is_moving, clock_ms, base_x,
                    base_y, input ready);
    modport sink (input valid, detail_level, ground_height, normal_x, normal_y, normal_z,
                  heading_cos, heading_sin, rel_heading, is_moving, clock_ms, base_x,
                  base_y, output ready);
endinterface

interface tasp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] member_x;
    logic signed [31:0] member_y;
    logic signed [31:0] member_z;
    logic [31:0]        walk_mask;
    logic [7:0]         pose_mask;
    logic               is_leader;
    logic               last;

    modport source (output valid, member_x, member_y, member_z, walk_mask, pose_mask,
                    is_leader, last, input ready);
    modport sink (input valid, member_x, member_y, member_z, walk_mask, pose_mask,
                  is_leader, last, output ready);
endinterface

interface tasp_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### design/tasp_dpath.sv
// ----------------------------------------------------------------------------
// tasp_dpath
// Datapath: request latch, shared multiplier, square root and divider for
// axis normalization, orientation frame, member placement and output register.
// ----------------------------------------------------------------------------
module tasp_dpath #(
    parameter int MAX_SQUAD = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tasp_pkg::tasp_cmd_t    cmd,
    output tasp_pkg::tasp_stat_t   stat,
    input  logic [3:0]             detail_level,
    input  logic signed [31:0]     ground_height,
    input  logic signed [15:0]     normal_x,
    input  logic signed [15:0]     normal_y,
    input  logic signed [15:0]     normal_z,
    input  logic signed [15:0]     heading_cos,
    input  logic signed [15:0]     heading_sin,
    input  logic [15:0]            rel_heading,
    input  logic                   is_moving,
    input  logic [31:0]            clock_ms,
    input  logic signed [31:0]     base_x,
    input  logic signed [31:0]     base_y,
    tasp_cfg_if.sink               cfg,
    tasp_out_if.source             placed
);

    localparam int VW = tasp_pkg::VW;
    localparam int PW = tasp_pkg::PW;
    localparam int SW = tasp_pkg::SW;
    localparam int NW = tasp_pkg::NW;
    localparam int RW = tasp_pkg::RW;
    localparam int DW = tasp_pkg::DW;

    logic [3:0]             size_reg;
    logic [4:0]             lvl_reg;
    logic signed [31:0]     ground_reg;
    logic signed [31:0]     bx_reg, by_reg;
    logic [31:0]            walk_reg;
    logic [7:0]             pose_reg;
    logic signed [16:0]     nx_reg, ny_reg, nz_reg;
    logic signed [15:0]     hc_reg, hs_reg;
    logic signed [PW-1:0]   p0_reg, p1_reg, p2_reg, p3_reg;
    tasp_pkg::vec_t         v_reg [0:2];
    logic [SW-1:0]          sum_reg;
    logic [NW-1:0]          rad_reg, root_reg, bit_reg;
    logic [DW-1:0]          dq_reg;
    logic [RW-1:0]          rem_reg;
    logic                   neg_reg;
    tasp_pkg::unit_t        fm_reg [0:5];

    logic                   ovalid_reg;
    logic signed [31:0]     ox_reg, oy_reg, oz_reg;
    logic [31:0]            owalk_reg;
    logic [7:0]             opose_reg;
    logic                   olead_reg, olast_reg;

    // input side combinational values
    logic [15:0]            dir_sum;
    logic [2:0]             dir;
    logic [1:0]             frm;
    logic [4:0]             wbit;

    assign dir_sum = rel_heading + 16'd4096;
    assign dir     = dir_sum[15:13];
    assign frm     = clock_ms[9:8];
    assign wbit    = {dir, frm};

    // shared heading multiplier
    logic signed [16:0]     ma;
    logic signed [15:0]     mb;
    logic signed [32:0]     prod;
    logic signed [PW-1:0]   prod_x;

    always_comb
    begin
        case (cmd.mul_step)
            3'd0:    begin ma = nz_reg; mb = hc_reg; end
            3'd1:    begin ma = nz_reg; mb = hs_reg; end
            3'd2:    begin ma = nx_reg; mb = hc_reg; end
            3'd3:    begin ma = ny_reg; mb = hs_reg; end
            3'd4:    begin ma = nx_reg; mb = hs_reg; end
            default: begin ma = ny_reg; mb = hc_reg; end
        endcase
    end

    assign prod   = ma * mb;
    assign prod_x = PW'(prod);

    // square accumulator
    tasp_pkg::vec_t         sq_v;
    logic signed [2*VW-1:0] sq;
    assign sq_v = (cmd.sq_idx == 2'd0) ? v_reg[0] : (cmd.sq_idx == 2'd1) ? v_reg[1] : v_reg[2];
    assign sq   = sq_v * sq_v;

    // square root step
    logic [NW-1:0] rb;
    assign rb = root_reg + bit_reg;

    // divider step
    logic [RW-1:0] root;
    logic [RW:0]   trial;
    logic          take;
    assign root  = root_reg[RW-1:0];
    assign trial = {rem_reg, dq_reg[DW-1]};
    assign take  = trial >= {1'b0, root};

    // divider setup
    tasp_pkg::vec_t dv;
    logic [VW-1:0]  dmag;
    assign dv   = cmd.comp ? v_reg[1] : v_reg[0];
    assign dmag = dv[VW-1] ? VW'(-dv) : VW'(dv);

    // quotient clamp to 16-bit signed
    tasp_pkg::unit_t qclamp;
    logic [16:0]     qneg;
    assign qneg = 17'(-dq_reg[16:0]);
    always_comb
    begin
        if (neg_reg)
            qclamp = (dq_reg > DW'(32768)) ? 16'sh8000 : tasp_pkg::unit_t'(qneg[15:0]);
        else
            qclamp = (dq_reg > DW'(32767)) ? 16'sh7fff : tasp_pkg::unit_t'(dq_reg[15:0]);
    end

    logic [2:0] widx;
    always_comb
    begin
        case (cmd.axis)
            2'd0:    widx = 3'd4;
            2'd1:    widx = 3'd0;
            default: widx = 3'd2;
        endcase
    end

    // member placement
    logic signed [5:0] ofx, ofy;
    assign ofx = tasp_pkg::off_x(cmd.k);
    assign ofy = tasp_pkg::off_y(cmd.k);

    function automatic logic signed [31:0] place(input logic signed [31:0] b,
                                                 input logic signed [5:0] a0,
                                                 input logic signed [5:0] a1,
                                                 input tasp_pkg::unit_t f0,
                                                 input tasp_pkg::unit_t f1);
        logic signed [22:0] s;
        logic [22:0]        mag;
        logic [22:0]        q;
        logic signed [17:0] r;
        logic signed [33:0] t;
        s   = 23'(a0) * 23'(f0) + 23'(a1) * 23'(f1);
        mag = s[22] ? 23'(-s) : 23'(s);
        q   = (mag + 23'd32) >> 6;
        r   = s[22] ? -$signed({1'b0, q[16:0]}) : $signed({1'b0, q[16:0]});
        t   = 34'(b) + 34'(r);
        if (t > 34'sh7fffffff)
            return 32'sh7fffffff;
        else if (t < -34'sh80000000)
            return 32'sh80000000;
        return t[31:0];
    endfunction

    // status
    assign stat.chg      = {1'b0, detail_level} != lvl_reg;
    assign stat.zero     = sum_reg == '0;
    assign stat.out_free = !ovalid_reg || placed.ready;
    assign stat.count    = (size_reg > 4'(MAX_SQUAD)) ? 4'(MAX_SQUAD) : size_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= 4'd1;
            lvl_reg    <= 5'd16;
            ground_reg <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                fm_reg[i] <= '0;
        end
        else
        begin
            if (cfg.valid)
                size_reg <= cfg.data;
            if (cmd.load && stat.chg)
            begin
                lvl_reg    <= {1'b0, detail_level};
                ground_reg <= ground_height;
            end
            if (cmd.div_store)
                fm_reg[widx + 3'(cmd.comp)] <= qclamp;
            if (cmd.zero_store)
            begin
                fm_reg[widx]        <= '0;
                fm_reg[widx + 3'd1] <= '0;
            end
            if (cmd.emit)
                ovalid_reg <= 1'b1;
            else if (placed.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bx_reg   <= base_x;
            by_reg   <= base_y;
            walk_reg <= is_moving ? (32'd1 << wbit) : 32'd0;
            pose_reg <= is_moving ? 8'd0 : (8'd1 << dir);
            nx_reg   <= -17'(normal_x);
            ny_reg   <= -17'(normal_y);
            nz_reg   <= -17'(normal_z);
            hc_reg   <= heading_cos;
            hs_reg   <= heading_sin;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_step)
                3'd0:    p0_reg <= prod_x;
                3'd1:    p1_reg <= prod_x;
                3'd2:    p2_reg <= prod_x;
                3'd3:    p2_reg <= p2_reg + prod_x;
                3'd4:    p3_reg <= prod_x;
                default: p3_reg <= p3_reg - prod_x;
            endcase
        end
        if (cmd.vec_load)
        begin
            sum_reg <= '0;
            case (cmd.axis)
                2'd0:
                begin
                    v_reg[0] <= VW'(nx_reg);
                    v_reg[1] <= VW'(ny_reg);
                    v_reg[2] <= VW'(nz_reg);
                end
                2'd1:
                begin
                    v_reg[0] <= tasp_pkg::round14(p0_reg);
                    v_reg[1] <= tasp_pkg::round14(p1_reg);
                    v_reg[2] <= -tasp_pkg::round14(p2_reg);
                end
                default:
                begin
                    v_reg[0] <= -tasp_pkg::round14(p1_reg);
                    v_reg[1] <= tasp_pkg::round14(p0_reg);
                    v_reg[2] <= tasp_pkg::round14(p3_reg);
                end
            endcase
        end
        if (cmd.sq_en)
            sum_reg <= sum_reg + SW'(sq);
        if (cmd.sqrt_init)
        begin
            rad_reg  <= {sum_reg, 20'd0};
            root_reg <= '0;
            bit_reg  <= NW'(1) << (NW - 2);
        end
        if (cmd.sqrt_step)
        begin
            if (rad_reg >= rb)
            begin
                rad_reg  <= rad_reg - rb;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            neg_reg <= dv[VW-1];
            dq_reg  <= DW'({dmag, 24'd0}) + DW'(root >> 1);
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= take ? RW'(trial - {1'b0, root}) : trial[RW-1:0];
            dq_reg  <= {dq_reg[DW-2:0], take};
        end
        if (cmd.emit)
        begin
            ox_reg    <= place(bx_reg, ofx, ofy, fm_reg[0], fm_reg[1]);
            oy_reg    <= place(by_reg, ofx, ofy, fm_reg[2], fm_reg[3]);
            oz_reg    <= place(ground_reg, ofx, ofy, fm_reg[4], fm_reg[5]);
            owalk_reg <= walk_reg;
            opose_reg <= pose_reg;
            olead_reg <= cmd.k == '0;
            olast_reg <= cmd.last;
        end
    end

    assign placed.valid     = ovalid_reg;
    assign placed.member_x  = ox_reg;
    assign placed.member_y  = oy_reg;
    assign placed.member_z  = oz_reg;
    assign placed.walk_mask = owalk_reg;
    assign placed.pose_mask = opose_reg;
    assign placed.is_leader = olead_reg;
    assign placed.last      = olast_reg;

endmodule

### design/tasp_ctrl.sv
// ----------------------------------------------------------------------------
// tasp_ctrl
// Sequencer: frame rebuild (products, three axis normalizations) and the
// member emission run.
// ----------------------------------------------------------------------------
module tasp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 ready,
    input  tasp_pkg::tasp_stat_t stat,
    output tasp_pkg::tasp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_VEC   = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DINIT = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DST   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    localparam logic [5:0] SQRT_LAST = 6'(tasp_pkg::SQRT_STEPS - 1);
    localparam logic [5:0] DIV_LAST  = 6'(tasp_pkg::DW - 1);

    logic [3:0]              state_reg, state_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [1:0]              axis_reg, axis_next;
    logic                    comp_reg, comp_next;
    logic [tasp_pkg::KW-1:0] k_reg, k_next;
    logic                    last_k;

    assign ready  = state_reg == S_IDLE;
    assign last_k = k_reg == stat.count - 4'd1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        comp_next  = comp_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.mul_step = cnt_reg[2:0];
        cmd.sq_idx   = cnt_reg[1:0];
        cmd.axis     = axis_reg;
        cmd.comp     = comp_reg;
        cmd.k        = k_reg;
        cmd.last     = last_k;
        case (state_reg)
            S_IDLE:
            begin
                if (valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    k_next   = '0;
                    axis_next = 2'd0;
                    if (stat.chg)
                        state_next = S_MUL;
                    else if (stat.count != '0)
                        state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd5)
                    state_next = S_VEC;
            end
            S_VEC:
            begin
                cmd.vec_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq_en = 1'b1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                cnt_next  = '0;
                comp_next = 1'b0;
                if (stat.zero)
                begin
                    // zero-length axis
                    cmd.zero_store = 1'b1;
                    axis_next      = axis_reg + 2'd1;
                    if (axis_reg != 2'd2)
                        state_next = S_VEC;
                    else
                        state_next = (stat.count != '0) ? S_EMIT : S_IDLE;
                end
                else
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                    state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_DST;
            end
            S_DST:
            begin
                cmd.div_store = 1'b1;
                if (!comp_reg)
                begin
                    comp_next  = 1'b1;
                    state_next = S_DINIT;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                    if (axis_reg != 2'd2)
                        state_next = S_VEC;
                    else
                        state_next = (stat.count != '0) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    k_next   = k_reg + 4'd1;
                    if (last_k)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= '0;
            comp_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
            comp_reg  <= comp_next;
            k_reg     <= k_next;
        end
    end

endmodule

### design/terrain_aligned_squad_placer.sv
// ----------------------------------------------------------------------------
// terrain_aligned_squad_placer
// Places squad members around a leader on a terrain-aligned frame and tags
// each with animation switch masks.
// ----------------------------------------------------------------------------
//   channel  dir  carries
//   item     in   one object request (detail level, ground, normal, heading, base)
//   placed   out  one member per cycle while taken, last marks the end of a run
//   cfg      in   squad_size write, always ready
//
// a request with an unchanged detail level goes straight to emitting and
// gives one member per cycle while placed is taken; a level change first
// rebuilds the frame: the heading products, then per axis the sum of squares,
// a square root and a division of two components by the axis length.
// reset clears the frame to zero and forces an update on the first request.
// a stalled placed channel holds the member and pauses the run; item is only
// taken once the previous run has been handed to the output register.
module terrain_aligned_squad_placer #(
    parameter int MAX_SQUAD = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    tasp_in_if.sink     item,
    tasp_out_if.source  placed,
    tasp_cfg_if.sink    cfg
);

    tasp_pkg::tasp_cmd_t  cmd;
    tasp_pkg::tasp_stat_t stat;
    logic                 rdy;

    assign item.ready = rdy;

    tasp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (item.valid),
        .ready (rdy),
        .stat  (stat),
        .cmd   (cmd)
    );

    tasp_dpath #(
        .MAX_SQUAD (MAX_SQUAD)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .detail_level  (item.detail_level),
        .ground_height (item.ground_height),
        .normal_x      (item.normal_x),
        .normal_y      (item.normal_y),
        .normal_z      (item.normal_z),
        .heading_cos   (item.heading_cos),
        .heading_sin   (item.heading_sin),
        .rel_heading   (item.rel_heading),
        .is_moving     (item.is_moving),
        .clock_ms      (item.clock_ms),
        .base_x        (item.base_x),
        .base_y        (item.base_y),
        .cfg           (cfg),
        .placed        (placed)
    );

endmodule
